FILE: rtl/asme_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and burst arithmetic for the AXI memory endpoint.
package asme_pkg;

    localparam int ADDR_W     = 32;
    localparam int ID_W       = 8;
    localparam int LEN_W      = 8;
    localparam int SIZE_W     = 3;
    localparam int DATA_W     = 64;
    localparam int BYTE_W     = 8;
    localparam int STRB_W     = DATA_W / BYTE_W;
    localparam int RESP_W     = 2;
    localparam int HS_W       = 5;
    localparam int BEAT_W     = 13;
    localparam int WORD_LSB   = $clog2(STRB_W);
    localparam int MEM_AW     = 16;
    localparam int MEM_WORDS  = 1 << MEM_AW;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [RESP_W-1:0] RESP_OK   = 2'b00;
    localparam logic [ADDR_W-1:0] ADDR_STEP = ADDR_W'(STRB_W);

    // Bit positions inside the handshakes field
    localparam int HS_AWVALID = 0;
    localparam int HS_WVALID  = 1;
    localparam int HS_BREADY  = 2;
    localparam int HS_ARVALID = 3;
    localparam int HS_RREADY  = 4;

    // Channel outputs known once an item has been classified
    typedef struct packed {
        logic            aw_ready;
        logic            w_ready;
        logic [ID_W-1:0] b_id;
        logic            b_valid;
        logic            ar_ready;
        logic [ID_W-1:0] r_id;
        logic            r_last;
        logic            r_valid;
    } out_meta_t;

    // One classified item handed from the front to the back
    typedef struct packed {
        out_meta_t         meta;
        logic              rd_en;
        logic [MEM_AW-1:0] rd_idx;
        logic              wr_en;
        logic [MEM_AW-1:0] wr_idx;
        logic [DATA_W-1:0] w_data;
        logic [STRB_W-1:0] w_strb;
    } cmd_t;

    // Beats of a burst: ceil(2^size * (len + 1) / 8)
    function automatic logic [BEAT_W-1:0] burst_beats(input logic [SIZE_W-1:0] size,
                                                     input logic [LEN_W-1:0]  len);
        logic [LEN_W:0] n;
        logic [15:0]    total;
        begin
            n     = {1'b0, len} + 9'd1;
            total = 16'(n) << size;
            return BEAT_W'((total + 16'd7) >> WORD_LSB);
        end
    endfunction

endpackage

FILE: rtl/asme_in_if.sv
`timescale 1ns / 1ps
// Input channel: one bus cycle of AW, W, B, AR and R inputs per word.
interface asme_in_if;
    logic                        valid;
    logic                        ready;
    logic [asme_pkg::ID_W-1:0]   aw_id;
    logic [asme_pkg::ADDR_W-1:0] aw_addr;
    logic [asme_pkg::LEN_W-1:0]  aw_len;
    logic [asme_pkg::SIZE_W-1:0] aw_size;
    logic [asme_pkg::DATA_W-1:0] w_data;
    logic [asme_pkg::STRB_W-1:0] w_strb;
    logic [asme_pkg::ID_W-1:0]   ar_id;
    logic [asme_pkg::ADDR_W-1:0] ar_addr;
    logic [asme_pkg::LEN_W-1:0]  ar_len;
    logic [asme_pkg::SIZE_W-1:0] ar_size;
    logic [asme_pkg::HS_W-1:0]   handshakes;

    modport source (output valid, aw_id, aw_addr, aw_len, aw_size, w_data, w_strb,
                    ar_id, ar_addr, ar_len, ar_size, handshakes, input ready);
    modport sink   (input valid, aw_id, aw_addr, aw_len, aw_size, w_data, w_strb,
                    ar_id, ar_addr, ar_len, ar_size, handshakes, output ready);
endinterface

FILE: rtl/asme_out_if.sv
`timescale 1ns / 1ps
// Output channel: one bus cycle of channel outputs per word.
interface asme_out_if;
    logic                        valid;
    logic                        ready;
    logic                        aw_ready;
    logic                        w_ready;
    logic [asme_pkg::ID_W-1:0]   b_id;
    logic [asme_pkg::RESP_W-1:0] b_resp;
    logic                        b_valid;
    logic                        ar_ready;
    logic [asme_pkg::ID_W-1:0]   r_id;
    logic [asme_pkg::DATA_W-1:0] r_data;
    logic [asme_pkg::RESP_W-1:0] r_resp;
    logic                        r_last;
    logic                        r_valid;

    modport source (output valid, aw_ready, w_ready, b_id, b_resp, b_valid, ar_ready,
                    r_id, r_data, r_resp, r_last, r_valid, input ready);
    modport sink   (input valid, aw_ready, w_ready, b_id, b_resp, b_valid, ar_ready,
                    r_id, r_data, r_resp, r_last, r_valid, output ready);
endinterface

FILE: rtl/asme_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered, read-first output.
module asme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/asme_front.sv
`timescale 1ns / 1ps
// Front end: read and write burst trackers that classify each bus cycle.
module asme_front (
    input  logic            clk,
    input  logic            rst_n,
    asme_in_if.sink         in_ch,
    input  logic            cmd_ready,
    output logic            cmd_valid,
    output asme_pkg::cmd_t  cmd
);
    import asme_pkg::*;

    logic              accept;
    logic              awvalid, wvalid, bready, arvalid, rready;

    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [ID_W-1:0]   rd_ident_reg, rd_ident_next;
    logic [BEAT_W-1:0] rd_left_reg, rd_left_next;
    logic              rd_first_reg, rd_first_next;
    logic [ID_W-1:0]   r_id_reg, r_id_next;
    logic              r_last_reg, r_last_next;

    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [ID_W-1:0]   wr_ident_reg, wr_ident_next;
    logic [BEAT_W-1:0] wr_left_reg, wr_left_next;
    logic [BEAT_W-1:0] wr_dec;
    logic              wr_pend_reg, wr_pend_next;
    logic [ID_W-1:0]   b_id_reg, b_id_next;

    assign accept    = in_ch.valid && cmd_ready;
    assign in_ch.ready = cmd_ready;
    assign cmd_valid = in_ch.valid;

    assign awvalid = in_ch.handshakes[HS_AWVALID];
    assign wvalid  = in_ch.handshakes[HS_WVALID];
    assign bready  = in_ch.handshakes[HS_BREADY];
    assign arvalid = in_ch.handshakes[HS_ARVALID];
    assign rready  = in_ch.handshakes[HS_RREADY];
    assign wr_dec  = wr_left_reg - BEAT_W'(1);

    // Read tracker: start, hold, send a beat or retire the burst
    always_comb
    begin
        rd_addr_next  = rd_addr_reg;
        rd_ident_next = rd_ident_reg;
        rd_left_next  = rd_left_reg;
        rd_first_next = rd_first_reg;
        r_id_next     = r_id_reg;
        r_last_next   = r_last_reg;
        cmd.meta.ar_ready = 1'b1;
        cmd.meta.r_valid  = 1'b0;
        cmd.rd_en         = 1'b0;
        cmd.rd_idx        = rd_addr_reg[WORD_LSB +: MEM_AW];
        if (rd_left_reg == '0 && arvalid)
        begin
            rd_addr_next      = in_ch.ar_addr;
            rd_ident_next     = in_ch.ar_id;
            rd_left_next      = burst_beats(in_ch.ar_size, in_ch.ar_len);
            rd_first_next     = 1'b1;
            cmd.meta.ar_ready = 1'b0;
        end
        else if (rd_left_reg != '0)
        begin
            if (!rready && !rd_first_reg)
            begin
                cmd.meta.ar_ready = 1'b0;
                cmd.meta.r_valid  = 1'b1;
            end
            else if (rd_left_reg == BEAT_W'(1) && !rd_first_reg)
            begin
                rd_left_next = '0;
            end
            else
            begin
                cmd.meta.ar_ready = 1'b0;
                cmd.meta.r_valid  = 1'b1;
                cmd.rd_en         = 1'b1;
                r_id_next         = rd_ident_reg;
                r_last_next       = rd_first_reg ? (rd_left_reg <= BEAT_W'(1))
                                                 : (rd_left_reg <= BEAT_W'(2));
                rd_addr_next      = rd_addr_reg + ADDR_STEP;
                if (rd_first_reg)
                begin
                    rd_first_next = 1'b0;
                end
                else
                begin
                    rd_left_next = rd_left_reg - BEAT_W'(1);
                end
            end
        end
        cmd.meta.r_id   = r_id_next;
        cmd.meta.r_last = r_last_next;

        // Write tracker: start, take beats, then hold the response until bready
        wr_addr_next  = wr_addr_reg;
        wr_ident_next = wr_ident_reg;
        wr_left_next  = wr_left_reg;
        wr_pend_next  = wr_pend_reg;
        b_id_next     = b_id_reg;
        cmd.meta.aw_ready = 1'b1;
        cmd.meta.w_ready  = 1'b0;
        cmd.meta.b_valid  = 1'b0;
        cmd.wr_en         = 1'b0;
        cmd.wr_idx        = wr_addr_reg[WORD_LSB +: MEM_AW];
        cmd.w_data        = in_ch.w_data;
        cmd.w_strb        = in_ch.w_strb;
        if (wr_left_reg == '0 && awvalid)
        begin
            wr_addr_next      = in_ch.aw_addr;
            wr_ident_next     = in_ch.aw_id;
            wr_left_next      = burst_beats(in_ch.aw_size, in_ch.aw_len);
            wr_pend_next      = 1'b0;
            cmd.meta.w_ready  = 1'b1;
            cmd.meta.aw_ready = 1'b0;
        end
        else if (wr_left_reg != '0)
        begin
            cmd.meta.w_ready  = 1'b1;
            cmd.meta.aw_ready = 1'b0;
            if (wr_pend_reg)
            begin
                cmd.meta.w_ready = 1'b0;
                if (bready)
                begin
                    cmd.meta.aw_ready = 1'b1;
                    wr_left_next      = '0;
                    wr_pend_next      = 1'b0;
                end
                else
                begin
                    cmd.meta.b_valid = 1'b1;
                end
            end
            else if (wvalid)
            begin
                cmd.wr_en    = 1'b1;
                wr_left_next = wr_dec;
                wr_addr_next = wr_addr_reg + ADDR_STEP;
                if (wr_dec == '0)
                begin
                    cmd.meta.b_valid = 1'b1;
                    b_id_next        = wr_ident_reg;
                    if (!bready)
                    begin
                        wr_pend_next     = 1'b1;
                        wr_left_next     = BEAT_W'(1);
                        cmd.meta.w_ready = 1'b0;
                    end
                end
            end
        end
        cmd.meta.b_id = b_id_next;
    end

    // Advance tracker state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg  <= '0;
            rd_ident_reg <= '0;
            rd_left_reg  <= '0;
            rd_first_reg <= 1'b0;
            r_id_reg     <= '0;
            r_last_reg   <= 1'b0;
            wr_addr_reg  <= '0;
            wr_ident_reg <= '0;
            wr_left_reg  <= '0;
            wr_pend_reg  <= 1'b0;
            b_id_reg     <= '0;
        end
        else if (accept)
        begin
            rd_addr_reg  <= rd_addr_next;
            rd_ident_reg <= rd_ident_next;
            rd_left_reg  <= rd_left_next;
            rd_first_reg <= rd_first_next;
            r_id_reg     <= r_id_next;
            r_last_reg   <= r_last_next;
            wr_addr_reg  <= wr_addr_next;
            wr_ident_reg <= wr_ident_next;
            wr_left_reg  <= wr_left_next;
            wr_pend_reg  <= wr_pend_next;
            b_id_reg     <= b_id_next;
        end
    end

    // A first beat only exists inside an active read burst
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_first_reg |-> rd_left_reg != '0)
        else $error("read first-beat flag set with no burst active");

    // A held write response parks the tracker on its last count
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> wr_left_reg == BEAT_W'(1))
        else $error("pending write response with wrong beat count");
endmodule

FILE: rtl/asme_cmd_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of classified words between front and back.
module asme_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  asme_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output asme_pkg::cmd_t  pop_cmd
);
    import asme_pkg::*;

    cmd_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               push, pop;

    assign push_ready = count_reg != FIFO_CW'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Occupancy never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("command queue overflow");
endmodule

FILE: rtl/asme_back.sv
`timescale 1ns / 1ps
// Back end: performs memory accesses in order and drives the output register.
module asme_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  asme_pkg::cmd_t  cmd,
    asme_out_if.source      out_ch
);
    import asme_pkg::*;

    logic              pop, o_move;
    logic [DATA_W-1:0] ram_q;

    logic              s_valid_reg, s_valid_next;
    out_meta_t         s_meta_reg;
    logic              s_rd_reg;

    logic              o_valid_reg, o_valid_next;
    out_meta_t         o_meta_reg;
    logic [DATA_W-1:0] o_rdata_reg;

    assign o_move    = s_valid_reg && (!o_valid_reg || out_ch.ready);
    assign pop       = cmd_valid && (!s_valid_reg || o_move);
    assign cmd_ready = !s_valid_reg || o_move;

    // One RAM per byte lane so strobes need no read-modify-write
    for (genvar i = 0; i < STRB_W; i++)
    begin : g_lane
        asme_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (MEM_WORDS)
        ) u_lane (
            .clk   (clk),
            .we    (pop && cmd.wr_en && cmd.w_strb[i]),
            .waddr (cmd.wr_idx),
            .wdata (cmd.w_data[BYTE_W*i +: BYTE_W]),
            .re    (pop && cmd.rd_en),
            .raddr (cmd.rd_idx),
            .rdata (ram_q[BYTE_W*i +: BYTE_W])
        );
    end

    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (pop)
        begin
            s_valid_next = 1'b1;
        end
        else if (o_move)
        begin
            s_valid_next = 1'b0;
        end
        o_valid_next = o_valid_reg;
        if (o_move)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    // Memory stage: hold the word while the RAM read completes
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s_meta_reg <= cmd.meta;
            s_rd_reg   <= cmd.rd_en;
        end
        if (o_move)
        begin
            o_meta_reg <= s_meta_reg;
        end
    end

    // Output register; read data holds its last beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            o_rdata_reg <= '0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            o_valid_reg <= o_valid_next;
            if (o_move && s_rd_reg)
            begin
                o_rdata_reg <= ram_q;
            end
        end
    end

    assign out_ch.valid    = o_valid_reg;
    assign out_ch.aw_ready = o_meta_reg.aw_ready;
    assign out_ch.w_ready  = o_meta_reg.w_ready;
    assign out_ch.b_id     = o_meta_reg.b_id;
    assign out_ch.b_resp   = RESP_OK;
    assign out_ch.b_valid  = o_meta_reg.b_valid;
    assign out_ch.ar_ready = o_meta_reg.ar_ready;
    assign out_ch.r_id     = o_meta_reg.r_id;
    assign out_ch.r_data   = o_rdata_reg;
    assign out_ch.r_resp   = RESP_OK;
    assign out_ch.r_last   = o_meta_reg.r_last;
    assign out_ch.r_valid  = o_meta_reg.r_valid;

    // A stalled memory stage keeps its word and, for a read, its RAM data
    assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg && !o_move |=> s_valid_reg && $stable(s_meta_reg)
                                   && (!s_rd_reg || $stable(ram_q)))
        else $error("memory stage lost its word during a stall");
endmodule

FILE: rtl/axi_slave_memory_endpoint.sv
`timescale 1ns / 1ps
// Top level of the cycle-level AXI slave memory endpoint.
//
//   Port     Dir  Payload                                          Accepted when
//   in_ch    in   aw_*, w_*, ar_*, handshakes (one bus cycle)      valid && ready
//   out_ch   out  aw/w/b/ar/r channel outputs (one bus cycle)      valid && ready
//
// One word is taken every cycle while in_ch.ready is high; the front trackers
// decide each word combinationally. A result passes the queue, then the memory
// stage, whose byte-lane RAMs return registered read data, then the output
// register before it is offered. Reset clears the trackers, queue and output
// register; memory is not cleared.
// A stalled output fills the memory stage, then the two-entry queue, then drops
// in_ch.ready.
module axi_slave_memory_endpoint (
    input  logic       clk,
    input  logic       rst_n,
    asme_in_if.sink    in_ch,
    asme_out_if.source out_ch
);
    import asme_pkg::*;

    logic front_valid, front_ready;
    cmd_t front_cmd;
    logic back_valid, back_ready;
    cmd_t back_cmd;

    asme_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_ready (front_ready),
        .cmd_valid (front_valid),
        .cmd       (front_cmd)
    );

    asme_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    asme_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .out_ch    (out_ch)
    );
endmodule

FILE: tb/sv/asme_cycle_watch.sv
`timescale 1ns / 1ps
// Cycle-by-cycle predictor and result checker for the AXI memory endpoint bench.
module asme_cycle_watch (
    input  logic        clk,
    input  logic        rst_n,
    asme_in_if          in_mon,
    asme_out_if         out_mon,
    output int unsigned errors,
    output int unsigned pending
);
    import asme_pkg::*;

    // One bus cycle of channel outputs
    typedef struct packed {
        logic              aw_ready;
        logic              w_ready;
        logic [ID_W-1:0]   b_id;
        logic [RESP_W-1:0] b_resp;
        logic              b_valid;
        logic              ar_ready;
        logic [ID_W-1:0]   r_id;
        logic [DATA_W-1:0] r_data;
        logic [RESP_W-1:0] r_resp;
        logic              r_last;
        logic              r_valid;
    } bus_cycle_t;

    // Read burst tracker and its held output registers
    logic [ADDR_W-1:0] rd_addr;
    logic [ID_W-1:0]   rd_id;
    int unsigned       rd_left;
    logic              rd_first;
    logic [DATA_W-1:0] r_data_q;
    logic [ID_W-1:0]   r_id_q;
    logic              r_last_q;

    // Write burst tracker and held response id
    logic [ADDR_W-1:0] wr_addr;
    logic [ID_W-1:0]   wr_id;
    int unsigned       wr_left;
    logic              wr_hold;
    logic [ID_W-1:0]   b_id_q;

    // Image of the word memory, keyed by word slot
    logic [DATA_W-1:0] mem_image [int unsigned];

    bus_cycle_t  cycle_q [$];
    int unsigned fail_count;
    int unsigned result_no;

    function automatic int unsigned burst_words(input logic [SIZE_W-1:0] sz,
                                                input logic [LEN_W-1:0]  ln);
        int unsigned total;
        total = (32'd1 << sz) * (32'(ln) + 32'd1);
        return (total + 32'd7) / 32'd8;
    endfunction

    function automatic int unsigned word_slot(input logic [ADDR_W-1:0] a);
        return (32'(a) >> WORD_LSB) % MEM_WORDS;
    endfunction

    function automatic string show(input bus_cycle_t c);
        return $sformatf({"aw_rdy=%b w_rdy=%b b_id=%h b_resp=%h b_v=%b ar_rdy=%b ",
                          "r_id=%h r_data=%h r_resp=%h r_last=%b r_v=%b"},
                         c.aw_ready, c.w_ready, c.b_id, c.b_resp, c.b_valid, c.ar_ready,
                         c.r_id, c.r_data, c.r_resp, c.r_last, c.r_valid);
    endfunction

    // Advance the trackers by one accepted word and return the outputs it causes
    function automatic bus_cycle_t next_cycle();
        bus_cycle_t        c;
        logic              aw_v, w_v, b_r, ar_v, r_r;
        int unsigned       slot;
        logic [DATA_W-1:0] merged;
        c          = '0;
        c.aw_ready = 1'b1;
        c.ar_ready = 1'b1;
        aw_v = in_mon.handshakes[HS_AWVALID];
        w_v  = in_mon.handshakes[HS_WVALID];
        b_r  = in_mon.handshakes[HS_BREADY];
        ar_v = in_mon.handshakes[HS_ARVALID];
        r_r  = in_mon.handshakes[HS_RREADY];

        // Read side goes first, so a same-cycle write is not yet visible
        if (rd_left == 0 && ar_v)
        begin
            rd_addr    = in_mon.ar_addr;
            rd_id      = in_mon.ar_id;
            rd_left    = burst_words(in_mon.ar_size, in_mon.ar_len);
            rd_first   = 1'b1;
            c.ar_ready = 1'b0;
        end
        else if (rd_left != 0)
        begin
            if (!r_r && !rd_first)
            begin
                c.ar_ready = 1'b0;
                c.r_valid  = 1'b1;
            end
            else if (rd_left == 1 && !rd_first)
            begin
                rd_left = 0;
            end
            else
            begin
                c.ar_ready = 1'b0;
                c.r_valid  = 1'b1;
                slot       = word_slot(rd_addr);
                r_data_q   = mem_image.exists(slot) ? mem_image[slot] : '0;
                r_id_q     = rd_id;
                // A two-beat burst must not mark its first beat
                r_last_q   = rd_first ? (rd_left <= 1) : (rd_left <= 2);
                rd_addr    = rd_addr + ADDR_STEP;
                if (rd_first)
                    rd_first = 1'b0;
                else
                    rd_left--;
            end
        end

        // Write side
        if (wr_left == 0 && aw_v)
        begin
            wr_addr    = in_mon.aw_addr;
            wr_id      = in_mon.aw_id;
            wr_left    = burst_words(in_mon.aw_size, in_mon.aw_len);
            wr_hold    = 1'b0;
            c.w_ready  = 1'b1;
            c.aw_ready = 1'b0;
        end
        else if (wr_left != 0)
        begin
            c.w_ready  = 1'b1;
            c.aw_ready = 1'b0;
            if (wr_hold)
            begin
                c.w_ready = 1'b0;
                if (b_r)
                begin
                    c.aw_ready = 1'b1;
                    wr_left    = 0;
                    wr_hold    = 1'b0;
                end
                else
                begin
                    c.b_valid = 1'b1;
                end
            end
            else if (w_v)
            begin
                slot   = word_slot(wr_addr);
                merged = mem_image.exists(slot) ? mem_image[slot] : '0;
                for (int b = 0; b < STRB_W; b++)
                    if (in_mon.w_strb[b])
                        merged[b*BYTE_W +: BYTE_W] = in_mon.w_data[b*BYTE_W +: BYTE_W];
                mem_image[slot] = merged;
                wr_left--;
                wr_addr = wr_addr + ADDR_STEP;
                if (wr_left == 0)
                begin
                    c.b_valid = 1'b1;
                    b_id_q    = wr_id;
                    // Hold the response until bready comes
                    if (!b_r)
                    begin
                        wr_hold   = 1'b1;
                        wr_left   = 1;
                        c.w_ready = 1'b0;
                    end
                end
            end
        end

        c.b_id   = b_id_q;
        c.b_resp = RESP_OK;
        c.r_id   = r_id_q;
        c.r_data = r_data_q;
        c.r_resp = RESP_OK;
        c.r_last = r_last_q;
        return c;
    endfunction

    task automatic flag_failure(input string what, input bit with_want,
                                input bus_cycle_t want, input bus_cycle_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("result %0d: %s", result_no, what);
            if (with_want)
                $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
        end
    endtask

    // Compare each accepted result word, then predict for each accepted input word
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        bus_cycle_t got;
        bus_cycle_t want;
        if (!rst_n)
        begin
            rd_addr    = '0;
            rd_id      = '0;
            rd_left    = 0;
            rd_first   = 1'b0;
            r_data_q   = '0;
            r_id_q     = '0;
            r_last_q   = 1'b0;
            wr_addr    = '0;
            wr_id      = '0;
            wr_left    = 0;
            wr_hold    = 1'b0;
            b_id_q     = '0;
            fail_count = 0;
            result_no  = 0;
            cycle_q.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got.aw_ready = out_mon.aw_ready;
                got.w_ready  = out_mon.w_ready;
                got.b_id     = out_mon.b_id;
                got.b_resp   = out_mon.b_resp;
                got.b_valid  = out_mon.b_valid;
                got.ar_ready = out_mon.ar_ready;
                got.r_id     = out_mon.r_id;
                got.r_data   = out_mon.r_data;
                got.r_resp   = out_mon.r_resp;
                got.r_last   = out_mon.r_last;
                got.r_valid  = out_mon.r_valid;
                if (cycle_q.size() == 0)
                begin
                    flag_failure("result word with no input word outstanding", 1'b0, got, got);
                end
                else
                begin
                    want = cycle_q.pop_front();
                    if (got !== want)
                        flag_failure("result word differs", 1'b1, want, got);
                end
                result_no++;
            end
            if (in_mon.valid && in_mon.ready)
                cycle_q.push_back(next_cycle());
            pending <= cycle_q.size();
            errors  <= fail_count;
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the AXI memory endpoint bench: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
    import asme_pkg::*;

    // Reads stay inside a window that is filled completely before any read
    localparam logic [MEM_AW-1:0] WIN_BASE     = 16'hFF00;
    localparam int unsigned       WIN_WORDS    = 512;
    localparam int unsigned       RANDOM_WORDS = 780;
    localparam int unsigned       CYCLE_LIMIT  = 500_000;
    localparam int unsigned       DRAIN_CYCLES = 20;

    typedef struct {
        logic [ID_W-1:0]   aw_id;
        logic [ADDR_W-1:0] aw_addr;
        logic [LEN_W-1:0]  aw_len;
        logic [SIZE_W-1:0] aw_size;
        logic [DATA_W-1:0] w_data;
        logic [STRB_W-1:0] w_strb;
        logic [ID_W-1:0]   ar_id;
        logic [ADDR_W-1:0] ar_addr;
        logic [LEN_W-1:0]  ar_len;
        logic [SIZE_W-1:0] ar_size;
        logic [HS_W-1:0]   hs;
    } bus_word_t;

    logic        clk;
    logic        rst_n;
    int unsigned errors;
    int unsigned pending;
    int unsigned cycle_no = 0;
    bit          calm     = 1'b0;

    asme_in_if  in_ch ();
    asme_out_if out_ch ();

    axi_slave_memory_endpoint dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    asme_cycle_watch watch (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_mon  (in_ch),
        .out_mon (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abandon the run if it hangs
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int unsigned burst_span(input logic [SIZE_W-1:0] sz,
                                               input logic [LEN_W-1:0]  ln);
        return ((32'd1 << sz) * (32'(ln) + 32'd1) + 32'd7) / 32'd8;
    endfunction

    function automatic logic [HS_W-1:0] hs_of(input bit aw_v, input bit w_v, input bit b_r,
                                             input bit ar_v, input bit r_r);
        logic [HS_W-1:0] h;
        h              = '0;
        h[HS_AWVALID]  = aw_v;
        h[HS_WVALID]   = w_v;
        h[HS_BREADY]   = b_r;
        h[HS_ARVALID]  = ar_v;
        h[HS_RREADY]   = r_r;
        return h;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    // Burst geometry: mostly a few words, now and then up to 256
    function automatic void pick_shape(output logic [SIZE_W-1:0] sz,
                                       output logic [LEN_W-1:0]  ln);
        int unsigned r;
        r = $urandom_range(0, 63);
        if (r == 0)
        begin
            ln = '1;
            sz = SIZE_W'($urandom_range(0, 3));
        end
        else if (r == 1)
        begin
            sz = '1;
            ln = LEN_W'($urandom_range(0, 15));
        end
        else if (r < 10)
        begin
            sz = SIZE_W'($urandom_range(0, 7));
            ln = LEN_W'($urandom_range(0, 3));
        end
        else
        begin
            sz = SIZE_W'($urandom_range(0, 3));
            ln = LEN_W'($urandom_range(0, 7));
        end
    endfunction

    // Random high and low address bits around a word slot inside the window
    function automatic logic [ADDR_W-1:0] window_addr(input int unsigned off);
        logic [ADDR_W-1:0] a;
        a                     = $urandom();
        a[WORD_LSB +: MEM_AW] = WIN_BASE + MEM_AW'(off);
        return a;
    endfunction

    // Random word; the first random words force the length and size extremes
    function automatic bus_word_t random_word(input int unsigned n);
        bus_word_t         w;
        logic [SIZE_W-1:0] sz;
        logic [LEN_W-1:0]  ln;
        w.aw_id = ID_W'($urandom());
        pick_shape(sz, ln);
        if (n < 60)
        begin
            sz = '0;
            ln = '1;
        end
        else if (n < 120)
        begin
            sz = '1;
            ln = '0;
        end
        w.aw_size = sz;
        w.aw_len  = ln;
        w.aw_addr = $urandom();
        w.w_data  = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0:       w.w_strb = '0;
            1:       w.w_strb = '1;
            default: w.w_strb = STRB_W'($urandom());
        endcase
        w.ar_id = ID_W'($urandom());
        pick_shape(sz, ln);
        if (n < 60)
        begin
            sz = '1;
            ln = '0;
        end
        else if (n < 120)
        begin
            sz = '0;
            ln = '1;
        end
        w.ar_size = sz;
        w.ar_len  = ln;
        w.ar_addr = window_addr($urandom_range(0, WIN_WORDS - burst_span(sz, ln)));
        w.hs = hs_of($urandom_range(0, 99) < 40, $urandom_range(0, 99) < 75,
                     $urandom_range(0, 99) < 70, $urandom_range(0, 99) < 40,
                     $urandom_range(0, 99) < 70);
        return w;
    endfunction

    // Present one word after a random gap and hold it until accepted
    task automatic send_word(input bus_word_t w);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.aw_id      <= w.aw_id;
        in_ch.aw_addr    <= w.aw_addr;
        in_ch.aw_len     <= w.aw_len;
        in_ch.aw_size    <= w.aw_size;
        in_ch.w_data     <= w.w_data;
        in_ch.w_strb     <= w.w_strb;
        in_ch.ar_id      <= w.ar_id;
        in_ch.ar_addr    <= w.ar_addr;
        in_ch.ar_len     <= w.ar_len;
        in_ch.ar_size    <= w.ar_size;
        in_ch.handshakes <= w.hs;
        in_ch.valid      <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result side back-pressure: runs of ready and stalls of random length
    initial
    begin : result_stall
        int unsigned hold;
        bit          rdy;
        hold         = 0;
        rdy          = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                if (calm || $urandom_range(0, 99) >= 30)
                begin
                    rdy  = 1'b1;
                    hold = calm ? 1 : $urandom_range(1, 12);
                end
                else
                begin
                    rdy  = 1'b0;
                    hold = 1 + pick_gap();
                end
            end
            out_ch.ready <= rdy;
            hold--;
        end
    end

    initial
    begin : stimulus
        bus_word_t   w;
        int unsigned n;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.aw_id      = '0;
        in_ch.aw_addr    = '0;
        in_ch.aw_len     = '0;
        in_ch.aw_size    = '0;
        in_ch.w_data     = '0;
        in_ch.w_strb     = '0;
        in_ch.ar_id      = '0;
        in_ch.ar_addr    = '0;
        in_ch.ar_len     = '0;
        in_ch.ar_size    = '0;
        in_ch.handshakes = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the read window with one 512-word burst that wraps the slot index
        w         = random_word(RANDOM_WORDS);
        w.aw_size = 3'd7;
        w.aw_len  = 8'd31;
        w.aw_addr = window_addr(0);
        w.hs      = hs_of(1, 0, 1, 0, 0);
        send_word(w);
        for (n = 0; n < WIN_WORDS; n++)
        begin
            w        = random_word(RANDOM_WORDS);
            w.w_strb = '1;
            w.hs     = hs_of(0, 1, 1, 0, 0);
            send_word(w);
        end

        // Single-word write and read together, both held by the far side
        w         = random_word(RANDOM_WORDS);
        w.aw_id   = '0;
        w.aw_size = 3'd3;
        w.aw_len  = '0;
        w.aw_addr = '1;
        w.ar_id   = '0;
        w.ar_size = '0;
        w.ar_len  = '0;
        w.ar_addr = ADDR_W'(WIN_BASE) << WORD_LSB;
        w.hs      = hs_of(1, 0, 1, 1, 1);
        send_word(w);
        w        = random_word(RANDOM_WORDS);
        w.w_data = '1;
        w.w_strb = '1;
        w.hs     = hs_of(0, 1, 0, 0, 0);
        send_word(w);
        w        = random_word(RANDOM_WORDS);
        w.w_data = '0;
        w.w_strb = '0;
        w.hs     = hs_of(0, 0, 0, 0, 0);
        send_word(w);
        w    = random_word(RANDOM_WORDS);
        w.hs = hs_of(0, 0, 1, 0, 1);
        send_word(w);

        // Two-beat read and write on the same words: the first read beat sees the old data
        w         = random_word(RANDOM_WORDS);
        w.aw_id   = '1;
        w.aw_size = 3'd3;
        w.aw_len  = 8'd1;
        w.aw_addr = window_addr(1);
        w.ar_id   = '1;
        w.ar_size = 3'd3;
        w.ar_len  = 8'd1;
        w.ar_addr = window_addr(1);
        w.hs      = hs_of(1, 0, 1, 1, 0);
        send_word(w);
        w        = random_word(RANDOM_WORDS);
        w.w_strb = 8'h5A;
        w.hs     = hs_of(0, 1, 1, 0, 0);
        send_word(w);
        w        = random_word(RANDOM_WORDS);
        w.w_strb = 8'hA5;
        w.hs     = hs_of(0, 1, 1, 0, 0);
        send_word(w);
        w    = random_word(RANDOM_WORDS);
        w.hs = hs_of(0, 0, 0, 0, 1);
        send_word(w);

        // Write at slot zero with a held response while a read starts there
        w         = random_word(RANDOM_WORDS);
        w.aw_id   = 8'h80;
        w.aw_size = '0;
        w.aw_len  = '0;
        w.aw_addr = window_addr(256);
        w.hs      = hs_of(1, 0, 0, 0, 1);
        send_word(w);
        w        = random_word(RANDOM_WORDS);
        w.w_strb = '0;
        w.hs     = hs_of(0, 1, 0, 0, 0);
        send_word(w);
        w         = random_word(RANDOM_WORDS);
        w.ar_id   = 8'h7F;
        w.ar_size = 3'd2;
        w.ar_len  = 8'd1;
        w.ar_addr = window_addr(256);
        w.hs      = hs_of(0, 0, 0, 1, 0);
        send_word(w);
        w    = random_word(RANDOM_WORDS);
        w.hs = hs_of(0, 0, 1, 0, 1);
        send_word(w);
        w    = random_word(RANDOM_WORDS);
        w.hs = hs_of(0, 0, 0, 0, 1);
        send_word(w);

        // Random traffic, with a stretch of no idling and one full drain
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            calm = (n >= 300 && n < 400);
            if (n == 700)
            begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                    @(negedge clk);
            end
            send_word(random_word(n));
        end
        in_ch.valid <= 1'b0;
        @(negedge clk);

        // Drain the outstanding results
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/asme_pkg.sv
rtl/asme_in_if.sv
rtl/asme_out_if.sv
rtl/asme_ram.sv
rtl/asme_front.sv
rtl/asme_cmd_fifo.sv
rtl/asme_back.sv
rtl/axi_slave_memory_endpoint.sv
tb/sv/asme_cycle_watch.sv
tb/sv/tb_top.sv
